[hw/rtl/scf_pkg.sv]
// shared constants, types and state codes for the console framer
package scf_pkg;

  // most text bytes per frame
  localparam int MAX_TEXT = 30;
  // buffer address and fill count widths
  localparam int ADDR_W = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int CNT_W  = $clog2(MAX_TEXT + 1);

  // frame constants
  localparam logic [7:0] SYNC1_BYTE = 8'hBC;
  localparam logic [7:0] SYNC2_BYTE = 8'hCF;
  localparam logic [7:0] TYPE_BYTE  = 8'h00;
  localparam logic [7:0] HDR_BYTE   = 8'h00;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SYNC1,
    S_SYNC2,
    S_TYPE,
    S_LEN,
    S_HDR,
    S_TEXT,
    S_CKA,
    S_CKB
  } scf_state_t;

  // access to the text buffer
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } scf_buf_req_t;

endpackage

[hw/rtl/scf_in_if.sv]
// input channel: console text words
interface scf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_write;

  modport source (output valid, output text_byte, output end_of_write, input ready);
  modport sink   (input valid, input text_byte, input end_of_write, output ready);
endinterface

[hw/rtl/scf_out_if.sv]
// output channel: framed link words
interface scf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

[hw/rtl/scf_text_buf.sv]
// text buffer: one write port, one registered read port
module scf_text_buf
  import scf_pkg::*;
(
  input  logic         clk,
  input  scf_buf_req_t req,
  output logic [7:0]   rd_data
);

  logic [7:0] mem_r [MAX_TEXT];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/syslink_console_framer_core.sv]
// top level of the console text framer with fletcher-8 checksum
//
// usage
//   in_chan  : one text word per handshake, with end_of_write on the last word of a write
//   out_chan : framed words bc cf 00 len 00 text.. ck_a ck_b, frame_end on ck_b
//   words collect in a buffer of MAX_TEXT entries; a frame goes out when the
//   buffer is full or the write ends
// timing
//   a word that does not close a frame leaves the input ready for the next word
//   a word that closes a frame blocks the input until the frame has drained,
//   one word a cycle through the output register while the receiver is ready
//   the first frame word is loaded into the output register in S_SYNC1, the state
//   after the closing word is taken; the text buffer read port (one read a cycle,
//   registered) is read one word ahead, so it does not slow the text words
// reset
//   fill count, checksum sums and output valid clear; buffer contents are not cleared
// stalls
//   a stalled receiver freezes the frame sequencer; the held word stays on the
//   output, and the input is taken again once the checksum word is loaded
module syslink_console_framer_core
  import scf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  scf_in_if.sink   in_chan,
  scf_out_if.source out_chan
);

  scf_state_t   state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] tx_idx_r, tx_idx_nxt;
  logic [7:0]   sum_a_r, sum_a_nxt;
  logic [7:0]   sum_b_r, sum_b_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_byte_r, out_byte_nxt;
  logic         out_end_r, out_end_nxt;

  logic         in_fire;
  logic         out_free;
  logic [CNT_W-1:0] fill_inc;
  logic [CNT_W-1:0] tx_inc;
  logic [7:0]   len_byte;
  logic [7:0]   ck_byte;
  logic         ck_load;
  logic [7:0]   rd_data;
  scf_buf_req_t buf_req;

  // buffer only accepts words while no frame is being sent
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  // output register can take a new word
  assign out_free      = !out_valid_r || out_chan.ready;

  assign fill_inc = fill_r + CNT_W'(1);
  assign tx_inc   = tx_idx_r + CNT_W'(1);
  assign len_byte = 8'(fill_r) + 8'd1;

  scf_text_buf u_buf (
    .clk     (clk),
    .req     (buf_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      tx_idx_r    <= '0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      tx_idx_r    <= tx_idx_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    tx_idx_nxt    = tx_idx_r;
    sum_a_nxt     = sum_a_r;
    sum_b_nxt     = sum_b_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    ck_load       = 1'b0;
    ck_byte       = 8'h00;
    buf_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // store the word at the fill position
          buf_req.wr_en   = 1'b1;
          buf_req.wr_addr = fill_r[ADDR_W-1:0];
          buf_req.wr_data = in_chan.text_byte;
          fill_nxt        = fill_inc;
          if (in_chan.end_of_write || (fill_inc == CNT_W'(MAX_TEXT))) begin
            state_nxt = S_SYNC1;
          end
        end
      end
      S_SYNC1: begin
        if (out_free) begin
          out_byte_nxt = SYNC1_BYTE;
          state_nxt    = S_SYNC2;
        end
      end
      S_SYNC2: begin
        if (out_free) begin
          out_byte_nxt = SYNC2_BYTE;
          state_nxt    = S_TYPE;
        end
      end
      S_TYPE: begin
        if (out_free) begin
          out_byte_nxt = TYPE_BYTE;
          ck_load      = 1'b1;
          ck_byte      = TYPE_BYTE;
          state_nxt    = S_LEN;
        end
      end
      S_LEN: begin
        if (out_free) begin
          out_byte_nxt = len_byte;
          ck_load      = 1'b1;
          ck_byte      = len_byte;
          state_nxt    = S_HDR;
        end
      end
      S_HDR: begin
        if (out_free) begin
          out_byte_nxt    = HDR_BYTE;
          ck_load         = 1'b1;
          ck_byte         = HDR_BYTE;
          // prefetch the first text word
          buf_req.rd_en   = 1'b1;
          buf_req.rd_addr = '0;
          tx_idx_nxt      = '0;
          state_nxt       = S_TEXT;
        end
      end
      S_TEXT: begin
        if (out_free) begin
          out_byte_nxt = rd_data;
          ck_load      = 1'b1;
          ck_byte      = rd_data;
          tx_idx_nxt   = tx_inc;
          if (tx_inc < fill_r) begin
            buf_req.rd_en   = 1'b1;
            buf_req.rd_addr = tx_inc[ADDR_W-1:0];
          end else begin
            state_nxt = S_CKA;
          end
        end
      end
      S_CKA: begin
        if (out_free) begin
          out_byte_nxt = sum_a_r;
          state_nxt    = S_CKB;
        end
      end
      S_CKB: begin
        if (out_free) begin
          out_byte_nxt = sum_b_r;
          out_end_nxt  = 1'b1;
          // frame done: clear buffer state for the next frame
          fill_nxt     = '0;
          sum_a_nxt    = '0;
          sum_b_nxt    = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // every load into the output register is a new word
    if (state_r != S_IDLE && out_free) begin
      out_valid_nxt = 1'b1;
      if (state_r != S_CKB) begin
        out_end_nxt = 1'b0;
      end
    end

    // running fletcher sums over type, length, header and text
    if (ck_load) begin
      sum_a_nxt = sum_a_r + ck_byte;
      sum_b_nxt = sum_b_r + sum_a_r + ck_byte;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.frame_end = out_end_r;

  // fill count never runs past the buffer
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_TEXT))
    else $error("fill count beyond buffer depth");

  // a closing word starts a frame on the next cycle
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_chan.end_of_write || fill_inc == CNT_W'(MAX_TEXT))
      |=> state_r == S_SYNC1)
    else $error("frame did not start after closing word");

  // text reads stay inside the filled part of the buffer
  a_text_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TEXT |-> tx_idx_r < fill_r)
    else $error("text index past fill count");

  // fill count and sums are clear once the second checksum word is loaded
  a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CKB && out_free |=> fill_r == '0 && sum_a_r == 8'h00 && sum_b_r == 8'h00)
    else $error("frame state not cleared after checksum");

endmodule

[tb/scf_link_checker.sv]
// checker for the console framer: predicts link words from accepted text words
module scf_link_checker
  import scf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  scf_in_if    in_mon,
  scf_out_if   out_mon,
  output int   fail_count,
  output int   pending_words,
  output int   frames_predicted,
  output int   full_frames,
  output int   words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } link_word_t;

  // shadow copy of the framer state
  logic [7:0]  text_buf [MAX_TEXT];
  int unsigned fill_cnt;
  logic [7:0]  run_a;
  logic [7:0]  run_b;

  // link words still to come, oldest first
  link_word_t  link_q[$];
  link_word_t  exp_w;
  int          n_err;
  int          n_frames;
  int          n_full;
  int          n_words;

  function automatic void push_word(logic [7:0] d, logic l);
    link_word_t w;
    w.data = d;
    w.last = l;
    link_q.push_back(w);
  endfunction

  // length and header enter the sums only when the frame closes
  function automatic void close_frame();
    logic [7:0] len_b;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    len_b = 8'(fill_cnt + 1);
    ck_a  = len_b + run_a;
    ck_b  = 8'(len_b * (fill_cnt + 2) + run_b);
    push_word(SYNC1_BYTE, 1'b0);
    push_word(SYNC2_BYTE, 1'b0);
    push_word(TYPE_BYTE, 1'b0);
    push_word(len_b, 1'b0);
    push_word(HDR_BYTE, 1'b0);
    for (int i = 0; i < int'(fill_cnt); i++) push_word(text_buf[i], 1'b0);
    push_word(ck_a, 1'b0);
    push_word(ck_b, 1'b1);
    n_frames++;
    if (fill_cnt == MAX_TEXT) n_full++;
    fill_cnt = 0;
    run_a    = '0;
    run_b    = '0;
  endfunction

  function automatic void take_text(logic [7:0] b, logic eow);
    if (fill_cnt < MAX_TEXT) begin
      text_buf[fill_cnt] = b;
      fill_cnt++;
      run_a = run_a + b;
      run_b = run_b + run_a;
    end
    if (fill_cnt >= MAX_TEXT || eow) close_frame();
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt = 0;
      run_a    = '0;
      run_b    = '0;
      link_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) take_text(in_mon.text_byte, in_mon.end_of_write);
      if (out_mon.valid && out_mon.ready) begin
        n_words++;
        if (link_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected link word, got %02h/%0b", $time,
                   out_mon.out_byte, out_mon.frame_end);
        end else begin
          exp_w = link_q.pop_front();
          if (out_mon.out_byte !== exp_w.data || out_mon.frame_end !== exp_w.last) begin
            n_err++;
            $display("%0t: link word mismatch, expected %02h/%0b, got %02h/%0b", $time,
                     exp_w.data, exp_w.last, out_mon.out_byte, out_mon.frame_end);
          end
        end
      end
    end
    fail_count       <= n_err;
    pending_words    <= link_q.size();
    frames_predicted <= n_frames;
    full_frames      <= n_full;
    words_checked    <= n_words;
  end

endmodule

[tb/tb_top.sv]
// testbench top for the console framer: clock, reset, stimulus and verdict
module tb_top
  import scf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  // long receiver hold, well past one frame of drain time
  localparam int LONG_HOLD    = 300;
  // quiet cycles after the last expected word, covers frame latency
  localparam int TAIL_CYCLES  = 60;
  // watchdog limit for a full run
  localparam int CYCLE_LIMIT  = 400000;
  // minimum text words per idle phase
  localparam int PHASE_WORDS  = 20;

  logic clk;
  logic rst_n;

  scf_in_if  in_chan();
  scf_out_if out_chan();

  int fail_total;
  int pending_words;
  int frames_total;
  int full_frames;
  int words_checked;

  int   text_sent    = 0;
  // sender idle chance, only the stimulus process reads it
  int   src_idle_pct = 0;
  // receiver stall chance, handed over by nonblocking assignment
  int   snk_idle_pct = 0;
  logic hold_req     = 1'b0;
  logic rx_hold;
  int   cycles;

  syslink_console_framer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  scf_link_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_chan),
    .out_mon          (out_chan),
    .fail_count       (fail_total),
    .pending_words    (pending_words),
    .frames_predicted (frames_total),
    .full_frames      (full_frames),
    .words_checked    (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // watchdog: a hung handshake or a lost word ends here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles, %0d link words outstanding", $time, cycles,
             pending_words);
    $display("Verification failed");
    $finish;
  end

  // long receiver hold, counted here so the sender keeps offering words meanwhile
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold <= 1'b0;
      end
    end
  end

  // receiver: random stalls per cycle, or held off entirely
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  task automatic set_idle(input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    snk_idle_pct <= snk_pct;
  endtask

  // offer one text word, with random gaps before it, and wait for the handshake
  task automatic send_word(input logic [7:0] b, input logic eow);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      // garbage on the bus while valid is low
      in_chan.valid        <= 1'b0;
      in_chan.text_byte    <= 8'($urandom);
      in_chan.end_of_write <= 1'($urandom);
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.text_byte    <= b;
    in_chan.end_of_write <= eow;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    text_sent++;
  endtask

  // one write call: mostly printable text, end flag on the last word only
  task automatic send_write(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) < 7) b = 8'($urandom_range(8'h20, 8'h7E));
      else b = 8'($urandom);
      send_word(b, i == len - 1);
    end
  endtask

  // sender goes quiet until every predicted link word has come out
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // write lengths: mostly short, some exactly a buffer, some spilling past it
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return MAX_TEXT;
    if (r < 22) return $urandom_range(MAX_TEXT + 1, 2 * MAX_TEXT + 3);
    return $urandom_range(1, 12);
  endfunction

  initial begin
    string greet;
    int    phase_n;
    int    len;
    int    src_mix [4];
    int    snk_mix [4];

    greet   = "hello\n";
    // no idling, sender idle, receiver stalling, both
    src_mix = '{0, 46, 0, 10};
    snk_mix = '{0, 0, 46, 10};

    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.text_byte    = '0;
    in_chan.end_of_write = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: shortest frames with extreme bytes, a short line, a run of ones
    set_idle(0, 0);
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b1);
    for (int i = 0; i < greet.len(); i++) send_word(greet[i], i == greet.len() - 1);
    for (int i = 0; i < 14; i++) send_word(8'hFF, i == 13);

    // receiver held off while a write fills the buffer twice over;
    // the block stalls its input once the first frame is waiting
    in_chan.valid <= 1'b0;
    hold_req      <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_write(2 * MAX_TEXT + 5);
    wait_drained();

    // random writes under each idle mix; the first write of the first mix is
    // exactly one buffer, so buffer full and end of write land on the same word
    for (int p = 0; p < 4; p++) begin
      set_idle(src_mix[p], snk_mix[p]);
      phase_n = 0;
      while (phase_n < PHASE_WORDS) begin
        len = (p == 0 && phase_n == 0) ? MAX_TEXT : pick_len();
        send_write(len);
        phase_n += len;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d text words in %0d frames, %0d of them closed by a full buffer",
             text_sent, frames_total, full_frames);
    $display("%0d link words checked under four idle mixes and one long receiver hold",
             words_checked);
    if (fail_total == 0 && pending_words == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/scf_pkg.sv
hw/rtl/scf_in_if.sv
hw/rtl/scf_out_if.sv
hw/rtl/scf_text_buf.sv
hw/rtl/syslink_console_framer_core.sv
tb/scf_link_checker.sv
tb/tb_top.sv
